FILE: rtl/one_euro_coordinate_filter_macros.svh
// ----------------------------------------------------------------------------
// one-euro coordinate filter assertion macros
// shared concurrent assertion forms for the filter checkers
// ----------------------------------------------------------------------------
`ifndef ONE_EURO_COORDINATE_FILTER_MACROS_SVH
`define ONE_EURO_COORDINATE_FILTER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OECF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OECF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/oecf_pkg.sv
// ----------------------------------------------------------------------------
// oecf_pkg
// types and fixed constants of the one-euro coordinate filter
// ----------------------------------------------------------------------------
`default_nettype none

package oecf_pkg;

   // field widths
   localparam int VALUE_W    = 21;
   localparam int CFG_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int SLOPE_W    = 32;
   localparam int OUTCOME_W  = 2;

   // |dv| * 1e6 fits in this many bits
   localparam int NUM_W      = 41;
   // wide operand port of the shared multiplier
   localparam int MUL_A_W    = 33;
   // divider iteration counter, holds NUM_W
   localparam int CNT_W      = 6;

   // elapsed time clamp for the alpha product
   localparam int          DT_CLAMP_W = 39;
   localparam logic [63:0] DT_CLAMP   = 64'd1 << 38;

   localparam logic [19:0]      USEC_PER_SEC = 20'd1000000;
   localparam logic [CFG_W-1:0] CFG_MAX      = {CFG_W{1'b1}};

   // register reset values
   localparam logic [CFG_W-1:0] MIN_CUTOFF_RESET   = 24'd3277;
   localparam logic [CFG_W-1:0] SPEED_GAIN_RESET   = 24'd5242880;
   localparam logic [CFG_W-1:0] DERIV_CUTOFF_RESET = 24'd65536;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_CUTOFF   = 2'd0,
      CSR_SPEED_GAIN   = 2'd1,
      CSR_DERIV_CUTOFF = 2'd2
   } csr_index_type;

   // result outcome codes
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_PASSED   = 2'd0,
      OUT_RESEEDED = 2'd1,
      OUT_FILTERED = 2'd2,
      OUT_CLEARED  = 2'd3
   } outcome_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NUM_MUL,
      ST_Q_LOAD,
      ST_Q_DIV,
      ST_SC_LO,
      ST_SC_HI,
      ST_SC_SUM,
      ST_P_LO,
      ST_P_HI,
      ST_P_SUM,
      ST_HALVE,
      ST_A_DIV,
      ST_LP_MUL,
      ST_LP_ADD,
      ST_CUT_MUL,
      ST_CUT_ADD,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/oecf_req_if.sv
// ----------------------------------------------------------------------------
// oecf_req_if
// sample request channel of the one-euro coordinate filter
// ----------------------------------------------------------------------------
`default_nettype none

interface oecf_req_if #(
   parameter int TIME_BITS = 48
);
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [oecf_pkg::VALUE_W-1:0] sample_value;
   logic        [TIME_BITS-1:0]         sample_time;
   logic        [oecf_pkg::CFG_W-1:0]   sample_scale;

   modport source (
      output valid, action, sample_value, sample_time, sample_scale,
      input  ready
   );

   modport sink (
      input  valid, action, sample_value, sample_time, sample_scale,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/oecf_rsp_if.sv
// ----------------------------------------------------------------------------
// oecf_rsp_if
// result channel of the one-euro coordinate filter
// ----------------------------------------------------------------------------
`default_nettype none

interface oecf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [oecf_pkg::VALUE_W-1:0]   filtered_value;
   logic        [oecf_pkg::OUTCOME_W-1:0] outcome;

   modport source (
      output valid, filtered_value, outcome,
      input  ready
   );

   modport sink (
      input  valid, filtered_value, outcome,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/oecf_csr_if.sv
// ----------------------------------------------------------------------------
// oecf_csr_if
// register write channel of the one-euro coordinate filter
// ----------------------------------------------------------------------------
`default_nettype none

interface oecf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [oecf_pkg::CSR_IDX_W-1:0]    index;
   logic [oecf_pkg::CFG_W-1:0]        data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/one_euro_coordinate_filter.sv
// ----------------------------------------------------------------------------
// one_euro_coordinate_filter
// adaptive one-euro low-pass filter for one coordinate stream, fixed point
// ----------------------------------------------------------------------------
// Each request carries a coordinate (signed, FRAC_BITS fraction bits), a
// microsecond timestamp and a derivative scale, and gives exactly one result.
// A clear request, a zero scale and a sample that is first or not newer than
// the last one go straight from acceptance to the finish state. A filtered
// sample runs through one shared 33 x 24 multiplier and one shared radix-2
// divider under a sequencer: a 41-step derivative quotient, then for each
// of the two low passes a halving loop of up to FRAC_BITS steps and a
// FRAC_BITS-step alpha division, both skipped when that cutoff is zero. The
// finish state holds the result while the previous result is still unread,
// and req ready stays low meanwhile.
// The result waits in an output register, so the next request is taken
// while it is unread.
// Register writes are taken every cycle and must only arrive while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module one_euro_coordinate_filter #(
   parameter int FRAC_BITS = 16,
   parameter int TIME_BITS = 48
) (
   input  logic       clock,
   input  logic       reset,
   oecf_req_if.sink   req_bus,
   oecf_rsp_if.source rsp_bus,
   oecf_csr_if.sink   csr_bus
);
   import oecf_pkg::*;

   localparam int AW      = FRAC_BITS + 1;
   localparam int MUL_B_W = (AW > CFG_W) ? AW : CFG_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SC_W    = PROD_W + MUL_A_W + 1;

   localparam logic [63:0]   RC_DEN    = (64'd159154943092 << FRAC_BITS) / 64'd1000000;
   localparam logic [63:0]   HALVE_LIM = 64'd1 << (62 - FRAC_BITS);
   localparam logic [AW-1:0] ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};

   // sequencer
   state_type state_ff, state_in;

   // configuration registers
   logic [CFG_W-1:0] min_cutoff_ff, min_cutoff_in;
   logic [CFG_W-1:0] speed_gain_ff, speed_gain_in;
   logic [CFG_W-1:0] deriv_cutoff_ff, deriv_cutoff_in;

   // filter state
   logic                      seeded_ff, seeded_in;
   logic [TIME_BITS-1:0]      prior_time_ff, prior_time_in;
   logic signed [VALUE_W-1:0] prior_raw_ff, prior_raw_in;
   logic signed [VALUE_W-1:0] prior_smoothed_ff, prior_smoothed_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;

   // working registers of one request
   logic signed [VALUE_W-1:0] v_ff, v_in;
   logic [TIME_BITS-1:0]      t_ff, t_in;
   logic [CFG_W-1:0]          scale_ff, scale_in;
   logic [TIME_BITS-1:0]      dt_ff, dt_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic                      dv_neg_ff, dv_neg_in;
   logic signed [SLOPE_W-1:0] deriv_ff, deriv_in;
   logic [CFG_W-1:0]          cutoff_ff, cutoff_in;
   logic                      pass_ff, pass_in;
   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W-1:0]         acc_ff, acc_in;
   logic [63:0]               p_ff, p_in;
   logic [63:0]               d_ff, d_in;
   logic signed [VALUE_W-1:0] result_ff, result_in;
   outcome_type               outcome_ff, outcome_in;

   // shared divider
   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      divisor_ff, divisor_in;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   outcome_type               rsp_outcome_ff, rsp_outcome_in;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;

   // datapath helpers
   logic                      req_fire;
   logic signed [VALUE_W-1:0] req_value;
   logic signed [VALUE_W:0]   dv_w;
   logic signed [VALUE_W:0]   dv_abs;
   logic [64:0]               rem_sh;
   logic                      div_fits;
   logic [64:0]               rem_sub;
   logic [63:0]               dt_wide;
   logic [DT_CLAMP_W-1:0]     dtc;
   logic [CFG_W-1:0]          fc_sel;
   logic [63:0]               pd_sum;
   logic [SC_W-1:0]           sc_full;
   logic [SC_W-1:0]           sc_shift;
   logic [SLOPE_W-2:0]        dmag;
   logic signed [32:0]        lp_x;
   logic signed [32:0]        lp_prev;
   logic signed [32:0]        lp_diff;
   logic signed [32:0]        lp_abs;
   logic signed [PROD_W:0]    lp_prod_s;
   logic signed [PROD_W:0]    lp_step;
   logic signed [32:0]        lp_y;
   logic signed [SLOPE_W-1:0] slope_abs;
   logic [PROD_W:0]           cut_sum;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign req_value     = req_bus.sample_value;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_value_ff;
   assign rsp_bus.outcome        = rsp_outcome_ff;

   // raw difference against the last sample
   assign dv_w   = (VALUE_W+1)'(req_value) - (VALUE_W+1)'(prior_raw_ff);
   assign dv_abs = dv_w[VALUE_W] ? -dv_w : dv_w;

   // one restoring division step
   assign rem_sh   = {rem_ff, dvd_ff[NUM_W-1]};
   assign div_fits = (rem_sh >= {1'b0, divisor_ff});
   assign rem_sub  = rem_sh - {1'b0, divisor_ff};

   // clamped elapsed time and cutoff of the current low pass
   assign dt_wide = 64'(dt_ff);
   assign dtc     = (dt_wide > DT_CLAMP) ? DT_CLAMP[DT_CLAMP_W-1:0]
                                         : dt_wide[DT_CLAMP_W-1:0];
   assign fc_sel  = pass_ff ? cutoff_ff : deriv_cutoff_ff;
   assign pd_sum  = p_ff + d_ff;

   // scaled derivative from the two partial products
   assign sc_full  = SC_W'(acc_ff) + (SC_W'(prod_ff) << MUL_A_W);
   assign sc_shift = sc_full >> FRAC_BITS;
   assign dmag     = (|sc_shift[SC_W-1:SLOPE_W-1]) ? {(SLOPE_W-1){1'b1}}
                                                    : sc_shift[SLOPE_W-2:0];

   // low pass operands: slope on the first pass, value on the second
   assign lp_x      = pass_ff ? 33'(v_ff) : 33'(deriv_ff);
   assign lp_prev   = pass_ff ? 33'(prior_smoothed_ff) : 33'(slope_ff);
   assign lp_diff   = lp_x - lp_prev;
   assign lp_abs    = lp_diff[32] ? -lp_diff : lp_diff;
   assign lp_prod_s = lp_diff[32] ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
   assign lp_step   = lp_prod_s >>> FRAC_BITS;
   assign lp_y      = lp_prev + $signed(lp_step[32:0]);

   // adaptive cutoff
   assign slope_abs = slope_ff[SLOPE_W-1] ? -slope_ff : slope_ff;
   assign cut_sum   = (PROD_W+1)'(min_cutoff_ff) + (PROD_W+1)'(prod_ff >> FRAC_BITS);

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // next state and datapath control
   always_comb begin
      state_in          = state_ff;
      min_cutoff_in     = min_cutoff_ff;
      speed_gain_in     = speed_gain_ff;
      deriv_cutoff_in   = deriv_cutoff_ff;
      seeded_in         = seeded_ff;
      prior_time_in     = prior_time_ff;
      prior_raw_in      = prior_raw_ff;
      prior_smoothed_in = prior_smoothed_ff;
      slope_in          = slope_ff;
      v_in              = v_ff;
      t_in              = t_ff;
      scale_in          = scale_ff;
      dt_in             = dt_ff;
      mag_in            = mag_ff;
      dv_neg_in         = dv_neg_ff;
      deriv_in          = deriv_ff;
      cutoff_in         = cutoff_ff;
      pass_in           = pass_ff;
      acc_in            = acc_ff;
      p_in              = p_ff;
      d_in              = d_ff;
      result_in         = result_ff;
      outcome_in        = outcome_ff;
      rem_in            = rem_ff;
      divisor_in        = divisor_ff;
      dvd_in            = dvd_ff;
      quo_in            = quo_ff;
      cnt_in            = cnt_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_value_in      = rsp_value_ff;
      rsp_outcome_in    = rsp_outcome_ff;
      mul_a             = '0;
      mul_b             = '0;

      // register writes
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MIN_CUTOFF:   min_cutoff_in   = csr_bus.data;
            CSR_SPEED_GAIN:   speed_gain_in   = csr_bus.data;
            CSR_DERIV_CUTOFF: deriv_cutoff_in = csr_bus.data;
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               v_in     = req_value;
               t_in     = req_bus.sample_time;
               scale_in = req_bus.sample_scale;
               if (req_bus.action) begin
                  seeded_in         = 1'b0;
                  prior_time_in     = '0;
                  prior_raw_in      = '0;
                  prior_smoothed_in = '0;
                  slope_in          = '0;
                  result_in         = '0;
                  outcome_in        = OUT_CLEARED;
                  state_in          = ST_FINISH;
               end else if (req_bus.sample_scale == '0) begin
                  result_in  = req_value;
                  outcome_in = OUT_PASSED;
                  state_in   = ST_FINISH;
               end else if (!seeded_ff || (req_bus.sample_time <= prior_time_ff)) begin
                  seeded_in         = 1'b1;
                  prior_time_in     = req_bus.sample_time;
                  prior_raw_in      = req_value;
                  prior_smoothed_in = req_value;
                  slope_in          = '0;
                  result_in         = req_value;
                  outcome_in        = OUT_RESEEDED;
                  state_in          = ST_FINISH;
               end else begin
                  dt_in     = req_bus.sample_time - prior_time_ff;
                  mag_in    = dv_abs[VALUE_W-1:0];
                  dv_neg_in = dv_w[VALUE_W];
                  pass_in   = 1'b0;
                  state_in  = ST_NUM_MUL;
               end
            end
         end

         // |dv| * 1e6
         ST_NUM_MUL: begin
            mul_a    = MUL_A_W'(mag_ff);
            mul_b    = MUL_B_W'(USEC_PER_SEC);
            state_in = ST_Q_LOAD;
         end

         ST_Q_LOAD: begin
            rem_in     = '0;
            dvd_in     = prod_ff[NUM_W-1:0];
            divisor_in = 64'(dt_ff);
            quo_in     = '0;
            cnt_in     = CNT_W'(NUM_W);
            state_in   = ST_Q_DIV;
         end

         // raw rate quotient, one bit per cycle
         ST_Q_DIV: begin
            rem_in = div_fits ? rem_sub[63:0] : rem_sh[63:0];
            quo_in = {quo_ff[NUM_W-2:0], div_fits};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_SC_LO;
            end
         end

         // rate times scale in two partial products
         ST_SC_LO: begin
            mul_a    = quo_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(scale_ff);
            state_in = ST_SC_HI;
         end

         ST_SC_HI: begin
            acc_in   = prod_ff;
            mul_a    = MUL_A_W'(quo_ff[NUM_W-1:MUL_A_W]);
            mul_b    = MUL_B_W'(scale_ff);
            state_in = ST_SC_SUM;
         end

         ST_SC_SUM: begin
            deriv_in = dv_neg_ff ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
            state_in = ST_P_LO;
         end

         // alpha: product of cutoff and clamped time, or one when the cutoff is zero
         ST_P_LO: begin
            if (fc_sel == '0) begin
               quo_in   = NUM_W'(ONE_Q);
               state_in = ST_LP_MUL;
            end else begin
               mul_a    = dtc[MUL_A_W-1:0];
               mul_b    = MUL_B_W'(fc_sel);
               state_in = ST_P_HI;
            end
         end

         ST_P_HI: begin
            acc_in   = prod_ff;
            mul_a    = MUL_A_W'(dtc[DT_CLAMP_W-1:MUL_A_W]);
            mul_b    = MUL_B_W'(fc_sel);
            state_in = ST_P_SUM;
         end

         ST_P_SUM: begin
            p_in     = 64'(acc_ff) + (64'(prod_ff) << MUL_A_W);
            d_in     = RC_DEN;
            state_in = ST_HALVE;
         end

         // halve both terms until the sum fits, then start the division
         ST_HALVE: begin
            if (pd_sum >= HALVE_LIM) begin
               p_in = p_ff >> 1;
               d_in = d_ff >> 1;
            end else begin
               rem_in     = p_ff;
               divisor_in = pd_sum;
               dvd_in     = '0;
               quo_in     = '0;
               cnt_in     = CNT_W'(FRAC_BITS);
               state_in   = ST_A_DIV;
            end
         end

         ST_A_DIV: begin
            rem_in = div_fits ? rem_sub[63:0] : rem_sh[63:0];
            quo_in = {quo_ff[NUM_W-2:0], div_fits};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_LP_MUL;
            end
         end

         // low pass: alpha times the step
         ST_LP_MUL: begin
            mul_a    = lp_abs;
            mul_b    = MUL_B_W'(quo_ff[AW-1:0]);
            state_in = ST_LP_ADD;
         end

         ST_LP_ADD: begin
            if (pass_ff) begin
               result_in         = lp_y[VALUE_W-1:0];
               prior_smoothed_in = lp_y[VALUE_W-1:0];
               prior_time_in     = t_ff;
               prior_raw_in      = v_ff;
               outcome_in        = OUT_FILTERED;
               state_in          = ST_FINISH;
            end else begin
               slope_in = lp_y[SLOPE_W-1:0];
               state_in = ST_CUT_MUL;
            end
         end

         // cutoff from the smoothed slope
         ST_CUT_MUL: begin
            mul_a    = {1'b0, slope_abs};
            mul_b    = MUL_B_W'(speed_gain_ff);
            state_in = ST_CUT_ADD;
         end

         ST_CUT_ADD: begin
            cutoff_in = (cut_sum > (PROD_W+1)'(CFG_MAX)) ? CFG_MAX : cut_sum[CFG_W-1:0];
            pass_in   = 1'b1;
            state_in  = ST_P_LO;
         end

         // hand the result to the output register
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = result_ff;
               rsp_outcome_in = outcome_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         min_cutoff_ff     <= MIN_CUTOFF_RESET;
         speed_gain_ff     <= SPEED_GAIN_RESET;
         deriv_cutoff_ff   <= DERIV_CUTOFF_RESET;
         seeded_ff         <= 1'b0;
         prior_time_ff     <= '0;
         prior_raw_ff      <= '0;
         prior_smoothed_ff <= '0;
         slope_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         min_cutoff_ff     <= min_cutoff_in;
         speed_gain_ff     <= speed_gain_in;
         deriv_cutoff_ff   <= deriv_cutoff_in;
         seeded_ff         <= seeded_in;
         prior_time_ff     <= prior_time_in;
         prior_raw_ff      <= prior_raw_in;
         prior_smoothed_ff <= prior_smoothed_in;
         slope_ff          <= slope_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      t_ff           <= t_in;
      scale_ff       <= scale_in;
      dt_ff          <= dt_in;
      mag_ff         <= mag_in;
      dv_neg_ff      <= dv_neg_in;
      deriv_ff       <= deriv_in;
      cutoff_ff      <= cutoff_in;
      pass_ff        <= pass_in;
      prod_ff        <= mul_p;
      acc_ff         <= acc_in;
      p_ff           <= p_in;
      d_ff           <= d_in;
      result_ff      <= result_in;
      outcome_ff     <= outcome_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      dvd_ff         <= dvd_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

endmodule

`default_nettype wire

FILE: rtl/oecf_checker.sv
// ----------------------------------------------------------------------------
// oecf_checker
// port-level assertions for the one-euro coordinate filter
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_euro_coordinate_filter_macros.svh"

module oecf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [oecf_pkg::VALUE_W-1:0] rsp_filtered_value,
   input wire logic [oecf_pkg::OUTCOME_W-1:0]     rsp_outcome
);
   import oecf_pkg::*;

   // a stalled result holds
   `OECF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered_value) && $stable(rsp_outcome), "stalled result changed")

   // one request at a time: busy right after an accepted request
   `OECF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // a cleared result carries zero
   `OECF_ASSERT_SAME(a_clear_zero, clock, reset, rsp_valid && (rsp_outcome == OUT_CLEARED), rsp_filtered_value == '0, "cleared result not zero")

   // no result straight out of reset
   `OECF_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind one_euro_coordinate_filter oecf_checker u_oecf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_filtered_value (rsp_bus.filtered_value),
   .rsp_outcome        (rsp_bus.outcome)
);

`default_nettype wire
